// File: rtl/mie_pkg.sv
// Shared types for the extended Euclidean modular inverse block.
// Holds the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package mie_pkg;

    // Commands from the controller, at most one high per cycle
    typedef struct packed {
        logic load;    // take a new operand pair, clear the divider
        logic step;    // one restoring-division bit
        logic update;  // close a Euclid step: shift remainders and coefficients
        logic finish;  // drive the result beat
    } t_dp_cmd;

    // Status back to the controller
    typedef struct packed {
        logic rem_zero;  // current remainder is zero: algorithm has converged
    } t_dp_status;

endpackage

// File: rtl/mie_ctrl.sv
// Controller for the modular inverse block: sequences Euclid steps and the
// bit-serial division inside each step. Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_ctrl import mie_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;

    assign busy = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.rem_zero) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_cnt   = CW'(WIDTH - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: rtl/mie_datapath.sv
// Datapath for the modular inverse block: remainder and coefficient registers,
// a restoring divider that also forms quotient times coefficient, result regs.
// Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_datapath import mie_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_inverse,
    output logic [WIDTH-1:0] o_common_divisor,
    output logic             o_has_inverse
);

    // Euclid state: remainders unsigned, coefficients two's complement W+1 bits
    logic [WIDTH-1:0] r_rprev, r_rcur;
    logic [WIDTH:0]   r_sprev, r_scur;
    // Divider state: partial remainder, dividend shifter, quotient*s_cur
    logic [WIDTH-1:0] r_rem, r_dq;
    logic [WIDTH:0]   r_prod;
    logic             r_valid;
    logic [WIDTH-1:0] r_inverse, r_gcd;
    logic             r_has_inv;

    logic [WIDTH:0]   rem_sh;
    logic             ge;
    logic [WIDTH:0]   rem_sub;
    logic [WIDTH:0]   prod_n;
    logic [WIDTH-1:0] coef_fix;

    assign o_status.rem_zero = (r_rcur == '0);

    // One restoring-division bit; the product tracks the quotient bits so far
    assign rem_sh  = {r_rem, r_dq[WIDTH-1]};
    assign ge      = (rem_sh >= {1'b0, r_rcur});
    assign rem_sub = rem_sh - {1'b0, r_rcur};
    assign prod_n  = {r_prod[WIDTH-1:0], 1'b0} + (ge ? r_scur : '0);

    // Negative coefficient brought into range by one modulus add
    assign coef_fix = r_sprev[WIDTH] ? (r_sprev[WIDTH-1:0] + i_modulus)
                                     : r_sprev[WIDTH-1:0];

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rprev <= i_value;
            r_rcur  <= i_modulus;
            r_sprev <= {{WIDTH{1'b0}}, 1'b1};
            r_scur  <= '0;
            r_rem   <= '0;
            r_dq    <= i_value;
            r_prod  <= '0;
        end else if (i_cmd.step) begin
            r_rem  <= ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            r_dq   <= {r_dq[WIDTH-2:0], 1'b0};
            r_prod <= prod_n;
        end else if (i_cmd.update) begin
            r_rprev <= r_rcur;
            r_rcur  <= r_rem;
            r_sprev <= r_scur;
            r_scur  <= r_sprev - r_prod;
            r_rem   <= '0;
            r_dq    <= r_rcur;
            r_prod  <= '0;
        end
        if (i_cmd.finish) begin
            r_inverse <= coef_fix;
            r_gcd     <= r_rprev;
            r_has_inv <= (r_rprev == {{(WIDTH-1){1'b0}}, 1'b1});
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_valid          = r_valid;
    assign o_inverse        = r_inverse;
    assign o_common_divisor = r_gcd;
    assign o_has_inverse    = r_has_inv;

endmodule

// File: rtl/modular_inverse_ext_euclid.sv
// Top level of the extended Euclidean modular inverse block.
// Instantiates mie_ctrl and mie_datapath; holds the modulus register. Uses mie_pkg.
`timescale 1ns / 1ps

// One operand is accepted when start is high and busy is low; the result beat
// follows on o_valid for exactly one cycle and cannot be held off, so the
// receiver must take it then. Each Euclid step is a check, a run of the
// one-bit-per-cycle restoring divider over all WIDTH quotient bits, and an
// update; the number of steps depends on the operands. The modulus resets to
// 1; the user must write it only while busy is low and no result is
// outstanding, since the block itself does not enforce this.

module modular_inverse_ext_euclid import mie_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_value,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_inverse,
    output logic [WIDTH-1:0] o_common_divisor,
    output logic             o_has_inverse
);

    logic [WIDTH-1:0] r_modulus;
    t_dp_cmd          cmd;
    t_dp_status       status;

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= {{(WIDTH-1){1'b0}}, 1'b1};
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    mie_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_value          (i_value),
        .i_modulus        (r_modulus),
        .o_valid          (o_valid),
        .o_inverse        (o_inverse),
        .o_common_divisor (o_common_divisor),
        .o_has_inverse    (o_has_inverse)
    );

endmodule
